// ===== hw/rtl/kts_pkg.sv =====
// Shared types, token codes and keyword table for the keyword token scanner.
`timescale 1ns / 1ps

package kts_pkg;

  localparam int MAX_NAME_CHARS_DEF = 32;
  localparam int NAME_BYTES         = 32;
  localparam int KW_COUNT           = 11;

  localparam logic [7:0] CODE_END     = 8'd128;
  localparam logic [7:0] CODE_IDENT   = 8'd129;
  localparam logic [7:0] CODE_NUMBER  = 8'd130;
  localparam logic [7:0] CODE_KW_BASE = 8'd131;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPZ   = 8'h5a;
  localparam logic [7:0] CH_US    = 8'h5f;
  localparam logic [7:0] CH_LOA   = 8'h61;
  localparam logic [7:0] CH_LOZ   = 8'h7a;

  // Keyword text, first character in the low byte, zero padded to six bytes.
  localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
    48'h000000726176,  // var
    48'h0000636e7566,  // func
    48'h000064696f76,  // void
    48'h000072616863,  // char
    48'h000000746e69,  // int
    48'h746375727473,  // struct
    48'h6e7275746572,  // return
    48'h000000006669,  // if
    48'h000065736c65,  // else
    48'h00656c696877,  // while
    48'h000074736163   // cast
  };
  localparam logic [5:0] KW_LEN [KW_COUNT] = '{
    6'd3, 6'd4, 6'd4, 6'd4, 6'd3, 6'd6, 6'd6, 6'd2, 6'd4, 6'd5, 6'd4
  };

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } kts_in_t;

  typedef struct packed {
    logic [7:0]  token_code;
    logic [31:0] number_value;
    logic [5:0]  name_length;
    logic [63:0] name_bytes_low;
    logic [63:0] name_bytes_second;
    logic [63:0] name_bytes_third;
    logic [63:0] name_bytes_high;
    logic [31:0] line_count;
    logic        last_of_run;
  } kts_out_t;

  // Tokens handed to the result queue in one cycle.
  typedef struct packed {
    logic [1:0] num;
    kts_out_t   tok0;
    kts_out_t   tok1;
  } kts_push_t;

  // Match a zero-padded name against the keyword table.
  function automatic logic [7:0] kw_lookup(input logic [47:0] text, input logic [5:0] len);
    logic [7:0] code;
    code = CODE_IDENT;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if (len == KW_LEN[i] && text == KW_TEXT[i]) begin
        code = CODE_KW_BASE + 8'(i);
      end
    end
    return code;
  endfunction

endpackage

// ===== hw/rtl/kts_result_queue.sv =====
// Three-entry result queue; the head entry drives the output channel.
`timescale 1ns / 1ps

module kts_result_queue
  import kts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  kts_push_t push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_stall,
  output kts_out_t  out_data
);

  kts_out_t   q_r [3];
  kts_out_t   q_nxt [3];
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [1:0] base;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q_r[0];
  assign pop       = out_valid && !out_stall;
  // Room for two tokens regardless of what the head does this cycle.
  assign room      = (cnt_r <= 2'd1);
  assign base      = cnt_r - {1'b0, pop};

  always_comb begin
    q_nxt[0] = pop ? q_r[1] : q_r[0];
    q_nxt[1] = pop ? q_r[2] : q_r[1];
    q_nxt[2] = q_r[2];
    for (int i = 0; i < 3; i++) begin
      if (push.num != 2'd0 && base == 2'(i)) begin
        q_nxt[i] = push.tok0;
      end
      if (push.num == 2'd2 && base + 2'd1 == 2'(i)) begin
        q_nxt[i] = push.tok1;
      end
    end
    cnt_nxt = base + push.num;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

// ===== hw/rtl/keyword_token_scanner.sv =====
// Top level of the keyword token scanner: input register, scan step, result queue.
`timescale 1ns / 1ps

// Streaming lexer. Each input request carries one source byte and an end
// flag; each output request carries one token with its code, number value,
// kept name characters and the line count at the time it was made.
// Both channels use valid/stall: a request moves on a rising edge with valid
// high and stall low.
// A byte accepted into the input register is scanned there, and its tokens
// are written into the result queue, whose head is offered on the output;
// the scan step waits while the queue lacks room. One byte is accepted per
// cycle unless the input stalls; a byte that both closes a name or number
// and forms a token of its own yields two tokens, which leave one per cycle
// while the output does not stall, and the input stalls while the
// three-entry result queue cannot take two more.
// The scan state (mode, name store, digit accumulator, line counter) sits
// in registers updated by the single scan step; names compare against all
// keywords at once.
// Reset (synchronous, active low) empties the input register and result
// queue, returns to idle and zeroes the line counter and accumulators.
// An output stall holds the head token; the queue fills, and once it holds
// two tokens the input register holds its byte and in_stall rises.

module keyword_token_scanner
  import kts_pkg::*;
#(
  parameter int MAX_NAME_CHARS = MAX_NAME_CHARS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  kts_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output kts_out_t out_data
);

  // Clamp the kept-name length to what the output fields can carry.
  localparam int NameDepth = (MAX_NAME_CHARS > NAME_BYTES) ? NAME_BYTES :
                             ((MAX_NAME_CHARS < 1) ? 1 : MAX_NAME_CHARS);
  localparam int IdxW      = (NameDepth > 1) ? $clog2(NameDepth) : 1;
  localparam logic [5:0] NameLimit = 6'(NameDepth);

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_NAME   = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;

  // Input register
  logic    item_vld_r;
  kts_in_t item_r;
  logic    fire;
  logic    room;
  logic    accept;

  // Scan state
  logic [1:0]  mode_r, mode_nxt;
  logic [7:0]  store_r [NameDepth];
  logic [5:0]  count_r, count_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] lines_r, lines_nxt;
  logic        store_wr;
  logic [IdxW-1:0] store_idx;

  logic [7:0]   name_byte [NAME_BYTES];
  logic [255:0] name_vec;

  kts_push_t push;

  assign accept   = in_valid && !in_stall;
  assign fire     = item_vld_r && room;
  assign in_stall = item_vld_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (accept) begin
      item_vld_r <= 1'b1;
    end else if (fire) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
  end

  // Kept name characters, zero past the count.
  for (genvar i = 0; i < NAME_BYTES; i++) begin : g_name
    if (i < NameDepth) begin : g_kept
      assign name_byte[i] = (count_r > 6'(i)) ? store_r[i] : 8'h00;
    end else begin : g_pad
      assign name_byte[i] = 8'h00;
    end
    assign name_vec[i*8 +: 8] = name_byte[i];
  end

  // Scan step
  always_comb begin
    logic [7:0] c;
    logic       eoi;
    logic       is_dig, is_alp, is_spc, name_ch;
    logic       flush, char_tok;
    kts_out_t   flush_t, char_t;

    c       = item_r.source_byte;
    eoi     = item_r.end_of_input;
    is_dig  = c inside {[CH_ZERO:CH_NINE]};
    is_alp  = c inside {[CH_LOA:CH_LOZ], [CH_UPA:CH_UPZ]};
    is_spc  = (c == CH_SPACE) || (c inside {[8'h09:8'h0d]});
    name_ch = is_alp || is_dig || (c == CH_US);

    mode_nxt  = mode_r;
    count_nxt = count_r;
    acc_nxt   = acc_r;
    lines_nxt = lines_r;
    store_wr  = 1'b0;
    store_idx = count_r[IdxW-1:0];
    flush     = 1'b0;
    char_tok  = 1'b0;

    flush_t            = '0;
    flush_t.line_count = lines_r;
    char_t             = '0;
    char_t.line_count  = lines_r;

    case (mode_r)
      MODE_NAME: begin
        if (!eoi && name_ch) begin
          // extend the name; drop characters past the limit
          if (count_r < NameLimit) begin
            store_wr  = 1'b1;
            count_nxt = count_r + 6'd1;
          end
        end else begin
          flush                     = 1'b1;
          flush_t.token_code        = kw_lookup(name_vec[47:0], count_r);
          flush_t.name_length       = count_r;
          flush_t.name_bytes_low    = name_vec[63:0];
          flush_t.name_bytes_second = name_vec[127:64];
          flush_t.name_bytes_third  = name_vec[191:128];
          flush_t.name_bytes_high   = name_vec[255:192];
        end
      end
      MODE_NUMBER: begin
        if (!eoi && is_dig) begin
          acc_nxt = {acc_r[28:0], 3'b000} + {acc_r[30:0], 1'b0} + {28'd0, c[3:0]};
        end else begin
          flush                = 1'b1;
          flush_t.token_code   = CODE_NUMBER;
          flush_t.number_value = acc_r;
        end
      end
      default: begin
        flush = 1'b0;
      end
    endcase

    // Scan the byte in its own right when no name or number absorbed it.
    if (flush || !(mode_r == MODE_NAME || mode_r == MODE_NUMBER)) begin
      mode_nxt = MODE_IDLE;
      if (eoi || c == CH_NUL || c[7]) begin
        char_tok          = 1'b1;
        char_t.token_code = CODE_END;
      end else if (is_spc) begin
        if (c == CH_NL) begin
          lines_nxt = lines_r + 32'd1;
        end
      end else if (is_dig) begin
        mode_nxt = MODE_NUMBER;
        acc_nxt  = {28'd0, c[3:0]};
      end else if (is_alp || c == CH_US) begin
        mode_nxt  = MODE_NAME;
        store_wr  = 1'b1;
        store_idx = '0;
        count_nxt = 6'd1;
      end else begin
        char_tok          = 1'b1;
        char_t.token_code = c;
      end
    end

    char_t.last_of_run  = 1'b1;
    flush_t.last_of_run = !char_tok;

    push.num  = 2'(flush) + 2'(char_tok);
    push.tok0 = flush ? flush_t : char_t;
    push.tok1 = char_t;
    if (!fire) begin
      push.num = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      count_r <= 6'd0;
      acc_r   <= 32'd0;
      lines_r <= 32'd0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      acc_r   <= acc_nxt;
      lines_r <= lines_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && store_wr) begin
      store_r[store_idx] <= item_r.source_byte;
    end
  end

  kts_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== test/keyword_token_scanner_test.sv =====
// Self-checking testbench for the keyword token scanner: stream driver, token monitor, scan predictor.
`timescale 1ns / 1ps

module keyword_token_scanner_test;
  import kts_pkg::*;

  // Characters the predictor needs beyond those the package names.
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0d;

  // Quiet cycles (nothing accepted on either side) before the run is abandoned.
  localparam int QUIET_LIMIT  = 5000;
  // Cycles to linger once the last token has arrived, as a margin.
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 850;

  typedef enum logic [1:0] {
    LEX_IDLE,
    LEX_NAME,
    LEX_NUMBER
  } lex_mode_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  kts_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  kts_out_t out_data;

  keyword_token_scanner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Requests waiting to be driven, and tokens the scan predictor has promised.
  kts_in_t  pending_requests [$];
  kts_out_t expected_tokens [$];

  // Predictor's own scan state.
  lex_mode_t   lex_mode = LEX_IDLE;
  logic [7:0]  name_chars [32];
  logic [5:0]  name_len = '0;
  logic [31:0] digit_value = '0;
  logic [31:0] lines_seen = '0;

  int mismatches = 0;
  int bytes_taken = 0;
  int tokens_checked = 0;
  int keyword_hits = 0;
  int long_names = 0;
  int random_pushed = 0;

  string name_alphabet = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";

  // ---------------------------------------------------------------------
  // Character classes and keyword table
  // ---------------------------------------------------------------------
  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= CH_LOA && c <= CH_LOZ) || (c >= CH_UPA && c <= CH_UPZ);
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_name_char(input logic [7:0] c);
    return is_letter(c) || is_digit(c) || c == CH_US;
  endfunction

  function automatic string keyword_text(input int idx);
    case (idx)
      0:       return "var";
      1:       return "func";
      2:       return "void";
      3:       return "char";
      4:       return "int";
      5:       return "struct";
      6:       return "return";
      7:       return "if";
      8:       return "else";
      9:       return "while";
      default: return "cast";
    endcase
  endfunction

  // Code for the kept name: a keyword code on an exact match, identifier otherwise.
  function automatic logic [7:0] classify_name();
    string word;
    bit    same;
    for (int k = 0; k < KW_COUNT; k++) begin
      word = keyword_text(k);
      if (word.len() == name_len) begin
        same = 1'b1;
        for (int i = 0; i < word.len(); i++) begin
          if (name_chars[i] != word[i]) same = 1'b0;
        end
        if (same) return CODE_KW_BASE + 8'(k);
      end
    end
    return CODE_IDENT;
  endfunction

  function automatic kts_out_t make_token(input logic [7:0] code, input logic [31:0] value,
                                          input bit with_name);
    kts_out_t     tok;
    logic [255:0] chars;
    tok   = '0;
    chars = '0;
    tok.token_code   = code;
    tok.number_value = value;
    if (with_name) begin
      tok.name_length = name_len;
      for (int i = 0; i < name_len; i++) chars[i*8 +: 8] = name_chars[i];
      tok.name_bytes_low    = chars[63:0];
      tok.name_bytes_second = chars[127:64];
      tok.name_bytes_third  = chars[191:128];
      tok.name_bytes_high   = chars[255:192];
    end
    tok.line_count = lines_seen;
    return tok;
  endfunction

  // ---------------------------------------------------------------------
  // Scan predictor: advance the state by one accepted request and queue
  // the tokens it causes.
  // ---------------------------------------------------------------------
  task automatic scan_byte(input kts_in_t req);
    logic [7:0] c;
    logic       eoi;
    logic [7:0] code;
    kts_out_t   made [$];
    c   = req.source_byte;
    eoi = req.end_of_input;

    // Close any pending name or number first; a continuing character just extends it.
    if (lex_mode == LEX_NAME) begin
      if (!eoi && is_name_char(c)) begin
        if (name_len < MAX_NAME_CHARS_DEF) begin
          name_chars[name_len[4:0]] = c;
          name_len = name_len + 6'd1;
        end
        return;
      end
      code = classify_name();
      if (code != CODE_IDENT) keyword_hits++;
      made.push_back(make_token(code, '0, 1'b1));
      lex_mode = LEX_IDLE;
    end else if (lex_mode == LEX_NUMBER) begin
      if (!eoi && is_digit(c)) begin
        digit_value = digit_value * 32'd10 + 32'(c - CH_ZERO);
        return;
      end
      made.push_back(make_token(CODE_NUMBER, digit_value, 1'b0));
      lex_mode = LEX_IDLE;
    end

    // Then scan the request in its own right.
    if (eoi || c == CH_NUL || c >= CODE_END) begin
      made.push_back(make_token(CODE_END, '0, 1'b0));
    end else if (is_blank(c)) begin
      if (c == CH_NL) lines_seen = lines_seen + 32'd1;
    end else if (is_digit(c)) begin
      lex_mode    = LEX_NUMBER;
      digit_value = 32'(c - CH_ZERO);
    end else if (is_letter(c) || c == CH_US) begin
      lex_mode      = LEX_NAME;
      name_chars[0] = c;
      name_len      = 6'd1;
    end else begin
      made.push_back(make_token(c, '0, 1'b0));
    end

    if (made.size() > 0) made[made.size() - 1].last_of_run = 1'b1;
    foreach (made[i]) expected_tokens.push_back(made[i]);
  endtask

  // ---------------------------------------------------------------------
  // Mismatch reporting
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("MISMATCH token %0d %s: got %0h, expected %0h", tokens_checked, what, got, want);
  endtask

  task automatic check_field(input string field, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) report_mismatch(field, got, want);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] c);
    kts_in_t req;
    req.source_byte  = c;
    req.end_of_input = 1'b0;
    pending_requests.push_back(req);
    random_pushed++;
  endtask

  // End flag: carry the given byte, which the scanner must ignore.
  task automatic push_end_flag(input logic [7:0] c);
    kts_in_t req;
    req.source_byte  = c;
    req.end_of_input = 1'b1;
    pending_requests.push_back(req);
    random_pushed++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] random_name_char();
    return name_alphabet[$urandom_range(0, 62)];
  endfunction

  function automatic logic [7:0] random_name_start();
    int r;
    r = $urandom_range(0, 52);
    return (r == 52) ? CH_US : name_alphabet[r];
  endfunction

  function automatic logic [7:0] random_punct();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 127));
    end while (is_name_char(c) || is_blank(c));
    return c;
  endfunction

  function automatic logic [7:0] random_end_byte();
    return ($urandom_range(0, 3) == 0) ? CH_NUL : 8'($urandom_range(128, 255));
  endfunction

  function automatic logic [7:0] random_blank();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_NL;
      default: return 8'($urandom_range(CH_TAB, CH_CR));
    endcase
  endfunction

  // Whatever follows a name or number: blank, punctuation, end, or nothing at all.
  task automatic push_separator();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: push_byte(random_blank());
      4, 5, 6:    push_byte(random_punct());
      7:          push_byte(random_end_byte());
      8:          push_end_flag(8'($urandom_range(0, 255)));
      default:    ;
    endcase
  endtask

  task automatic push_random_sequence();
    string word;
    int    len;
    case ($urandom_range(0, 11))
      0, 1, 2: begin
        push_text(keyword_text($urandom_range(0, KW_COUNT - 1)));
        push_separator();
      end
      3: begin
        // Near miss: a keyword with one character more or one fewer.
        word = keyword_text($urandom_range(0, KW_COUNT - 1));
        if ($urandom_range(0, 1)) begin
          push_text(word);
          push_byte(random_name_char());
        end else begin
          push_text(word.substr(0, word.len() - 2));
        end
        push_separator();
      end
      4, 5: begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
        if (len > MAX_NAME_CHARS_DEF) long_names++;
        push_byte(random_name_start());
        for (int i = 1; i < len; i++) push_byte(random_name_char());
        push_separator();
      end
      6, 7: begin
        // Ten digits or more overflow 32 bits now and then.
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 4);
        for (int i = 0; i < len; i++) push_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
        push_separator();
      end
      8: begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) push_byte(random_blank());
      end
      9: begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) push_byte(random_punct());
      end
      10: begin
        if ($urandom_range(0, 1)) push_byte(random_end_byte());
        else push_end_flag(8'($urandom_range(0, 255)));
      end
      default: begin
        // Noise: any byte, with the end flag now and then.
        if ($urandom_range(0, 5) == 0) push_end_flag(8'($urandom_range(0, 255)));
        else push_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Driver: offer requests in bursts with gaps; hold the payload while
  // the scanner stalls, and predict each request as it is accepted.
  // ---------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        scan_byte(in_data);
        bytes_taken++;
      end
      // Only move on once the current request has gone (or none was offered).
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_requests.pop_front();
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            // Pick the next burst: now and then a long one with no idling at all.
            if ($urandom_range(0, 5) == 0) begin
              burst_left = $urandom_range(60, 150);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 12);
              gap_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                       : $urandom_range(0, 5);
            end
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compare each accepted token with the oldest expectation, and
  // stall the result side on a pattern that changes mode from time to time.
  // ---------------------------------------------------------------------
  int       stall_mode = 0;
  int       mode_left = 0;
  int       wave_count = 0;
  int       wave_on = 1;
  int       wave_off = 1;
  kts_out_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch("unexpected token, code", 64'(out_data.token_code), '0);
      end else begin
        want = expected_tokens.pop_front();
        check_field("token_code",        64'(out_data.token_code),   64'(want.token_code));
        check_field("number_value",      64'(out_data.number_value), 64'(want.number_value));
        check_field("name_length",       64'(out_data.name_length),  64'(want.name_length));
        check_field("name_bytes_low",    out_data.name_bytes_low,    want.name_bytes_low);
        check_field("name_bytes_second", out_data.name_bytes_second, want.name_bytes_second);
        check_field("name_bytes_third",  out_data.name_bytes_third,  want.name_bytes_third);
        check_field("name_bytes_high",   out_data.name_bytes_high,   want.name_bytes_high);
        check_field("line_count",        64'(out_data.line_count),   64'(want.line_count));
        check_field("last_of_run",       64'(out_data.last_of_run),  64'(want.last_of_run));
      end
      tokens_checked++;
    end

    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(50, 300);
      wave_on    = $urandom_range(1, 6);
      wave_off   = $urandom_range(1, 6);
      wave_count = 0;
    end
    mode_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;                           // drain freely
      1: out_stall <= ($urandom_range(0, 3) == 0);    // light back-pressure
      2: out_stall <= ($urandom_range(0, 3) != 0);    // heavy back-pressure
      default: begin                                  // square wave
        out_stall  <= (wave_count < wave_on);
        wave_count  = (wave_count + 1) % (wave_on + wave_off);
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Watchdog: abandon the run when nothing moves for too long.
  // ---------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: nothing accepted for %0d cycles, %0d tokens outstanding",
               QUIET_LIMIT, expected_tokens.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: reset, directed requests, first random half, pause until the
  // scanner has drained, second random half, drain, verdict.
  // ---------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: keyword closed by punctuation, number closed by newline,
    // the byte extremes, the end flag flushing a name while carrying a letter,
    // a number closed by a high byte, and an identifier closed by a one-character token.
    push_text("if(");
    push_text("9\n");
    push_byte(CH_NUL);
    push_byte(8'hff);
    push_byte(8'h80);
    push_byte(8'h7f);
    push_byte(8'h01);
    push_text("_Z9");
    push_end_flag(CH_LOA);
    push_text("42");
    push_byte(8'hff);
    push_text("x+");
    push_text("while;");
    push_end_flag(8'hff);

    random_pushed = 0;
    while (random_pushed < RANDOM_ITEMS / 2) push_random_sequence();

    // Hold the sender back until every promised token has come out; sample
    // between edges so the driver's updates have settled.
    while (pending_requests.size() != 0 || in_valid || expected_tokens.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    while (random_pushed < RANDOM_ITEMS) push_random_sequence();
    push_end_flag(8'($urandom_range(0, 255)));

    while (pending_requests.size() != 0 || in_valid || expected_tokens.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_tokens.size() != 0)
      report_mismatch("tokens never produced", '0, 64'(expected_tokens.size()));

    $display("Scanned %0d source requests into %0d tokens (%0d keywords, %0d over-long names),",
             bytes_taken, tokens_checked, keyword_hits, long_names);
    $display("with bursty input, changing output back-pressure and one full drain mid-run.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
